>>> sv/sfcs_pkg.sv
// Shared types, constants and helpers of the SPI NOR flash command sequencer.
// No dependencies; used by the top level and all modules.
`timescale 1ns / 1ps
package sfcs_pkg;
	localparam int ADDR_BYTES = 3;

	localparam logic [1:0] RK_SPI  = 2'd0;
	localparam logic [1:0] RK_HOST = 2'd1;
	localparam logic [1:0] RK_NEED = 2'd2;
	localparam logic [1:0] RK_DONE = 2'd3;

	localparam logic [3:0] LG_MIN = 4'd4;
	localparam logic [3:0] LG_MAX = 4'd12;
	localparam logic [3:0] LG_RST = 4'd8;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] spi_byte;
		logic       cs_release;
		logic [7:0] host_byte;
		logic       ok;
		logic       last;
	} res_t;

	typedef struct packed {
		res_t [1:0] r;
		logic [1:0] n;
	} res_grp_t;

	function automatic res_t mk_spi(input logic [7:0] b, input logic cs);
		res_t r;
		r = '0;
		r.out_kind = RK_SPI;
		r.spi_byte = b;
		r.cs_release = cs;
		return r;
	endfunction

	function automatic res_t mk_host(input logic [7:0] b);
		res_t r;
		r = '0;
		r.out_kind = RK_HOST;
		r.host_byte = b;
		return r;
	endfunction

	function automatic res_t mk_need();
		res_t r;
		r = '0;
		r.out_kind = RK_NEED;
		return r;
	endfunction

	function automatic res_t mk_done(input logic ok);
		res_t r;
		r = '0;
		r.out_kind = RK_DONE;
		r.ok = ok;
		return r;
	endfunction
endpackage

>>> sv/sfcs_if.sv
// Request and result channel interfaces of the flash command sequencer.
// No dependencies.
`timescale 1ns / 1ps
interface sfcs_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [23:0] address;
	logic [15:0] length;
	logic [7:0]  data_byte;
	modport source (output valid, kind, address, length, data_byte, input ready);
	modport sink (input valid, kind, address, length, data_byte, output ready);
endinterface

interface sfcs_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] spi_byte;
	logic       cs_release;
	logic [7:0] host_byte;
	logic       ok;
	logic       last;
	modport source (output valid, out_kind, spi_byte, cs_release, host_byte, ok, last,
		input ready);
	modport sink (input valid, out_kind, spi_byte, cs_release, host_byte, ok, last,
		output ready);
endinterface

>>> sv/spi_nor_flash_command_sequencer_unit.sv
// Top level of the SPI NOR flash command sequencer: APB register, core, result queue.
// Depends on sfcs_pkg, sfcs_if, sfcs_core and sfcs_rq.
//
//   channel  dir  payload
//   req      in   kind, address, length, data_byte
//   res      out  out_kind, spi_byte, cs_release, host_byte, ok, last
//   apb      in   page_size_log2 at byte address 0
//
// A request is stepped in the cycle it is accepted; its zero to two results
// enter a two-group queue and leave one per cycle, so one request per cycle
// is taken while the queue has room. Reset idles the sequencer and sets page
// size log2 to 8. A stalled res side holds the queue; req stalls when full.
`timescale 1ns / 1ps
module spi_nor_flash_command_sequencer_unit (
	input  logic          clk,
	input  logic          arst_n,
	sfcs_req_if.sink      req,
	sfcs_res_if.source    res,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	logic [3:0]         lg_q;
	logic               take, room;
	logic [1:0]         qcnt;
	sfcs_pkg::res_grp_t grp;
	sfcs_pkg::res_t     head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {28'd0, lg_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q <= sfcs_pkg::LG_RST;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			lg_q <= pwdata[3:0];
		end
	end

	assign req.ready = room;
	assign take = req.valid && room;

	sfcs_core u_core (
		.clk(clk), .arst_n(arst_n), .take(take),
		.kind(req.kind), .address(req.address), .length(req.length),
		.data_byte(req.data_byte), .page_lg(lg_q), .grp(grp)
	);

	sfcs_rq u_rq (
		.clk(clk), .arst_n(arst_n), .grp(grp), .room(room),
		.vld(res.valid), .pop(res.ready), .head(head), .count(qcnt)
	);

	assign res.out_kind = head.out_kind;
	assign res.spi_byte = head.spi_byte;
	assign res.cs_release = head.cs_release;
	assign res.host_byte = head.host_byte;
	assign res.ok = head.ok;
	assign res.last = head.last;

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n) qcnt != 2'd3)
		else $error("result queue overfilled");
	a_push_valid: assert property (@(posedge clk) disable iff (!arst_n)
		grp.n != 2'd0 |=> res.valid)
		else $error("pushed results not visible");
	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.out_kind == sfcs_pkg::RK_DONE || res.out_kind == sfcs_pkg::RK_NEED)
		|-> res.last)
		else $error("done or need result not marked last");
endmodule

>>> sv/sfcs_core.sv
// Sequencer state and per-request step logic; produces up to two results.
// Depends on sfcs_pkg.
`timescale 1ns / 1ps
module sfcs_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [2:0]       kind,
	input  logic [23:0]      address,
	input  logic [15:0]      length,
	input  logic [7:0]       data_byte,
	input  logic [3:0]       page_lg,
	output sfcs_pkg::res_grp_t grp
);
	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_ADDR_RD = 4'd1;
	localparam logic [3:0] PH_ADDR_WR = 4'd2;
	localparam logic [3:0] PH_RDATA = 4'd3;
	localparam logic [3:0] PH_WREN = 4'd4;
	localparam logic [3:0] PH_WAIT_WDATA = 4'd5;
	localparam logic [3:0] PH_WDATA = 4'd6;
	localparam logic [3:0] PH_POLL_CMD = 4'd7;
	localparam logic [3:0] PH_POLL_STAT = 4'd8;
	localparam logic [3:0] PH_ID = 4'd9;
	localparam logic [3:0] PH_DRAIN = 4'd10;

	localparam logic [1:0] OP_READ = 2'd0;
	localparam logic [1:0] OP_PROGRAM = 2'd1;
	localparam logic [1:0] OP_ERASE = 2'd2;
	localparam logic [1:0] OP_ID = 2'd3;

	localparam logic [2:0] K_READ = 3'd0;
	localparam logic [2:0] K_PROG = 3'd1;
	localparam logic [2:0] K_ERASE = 3'd2;
	localparam logic [2:0] K_ID = 3'd3;
	localparam logic [2:0] K_RESP = 3'd4;
	localparam logic [2:0] K_WDATA = 3'd5;

	localparam logic [2:0] FI_START = 3'(sfcs_pkg::ADDR_BYTES);

	logic [3:0]  phase_q, phase_d;
	logic [1:0]  op_q, op_d;
	logic [23:0] cur_q, cur_d;
	logic [15:0] left_q, left_d;
	logic [12:0] pleft_q, pleft_d;
	logic [23:0] sav_addr_q, sav_addr_d;
	logic [15:0] sav_len_q, sav_len_d;
	logic [2:0]  fi_q, fi_d;

	function automatic logic [12:0] page_room(input logic [23:0] a, input logic [15:0] b,
		input logic [3:0] lg_in);
		logic [3:0]  lg;
		logic [12:0] ps;
		logic [12:0] room;
		lg = lg_in;
		if (lg < sfcs_pkg::LG_MIN) lg = sfcs_pkg::LG_MIN;
		if (lg > sfcs_pkg::LG_MAX) lg = sfcs_pkg::LG_MAX;
		ps = 13'd1 << lg;
		room = ps - (a[12:0] & (ps - 13'd1));
		return (b < {3'd0, room}) ? b[12:0] : room;
	endfunction

	function automatic logic [7:0] addr_byte(input logic [23:0] a, input logic [2:0] fi);
		logic [7:0] b;
		unique case (fi)
			3'd0: b = a[7:0];
			3'd1: b = a[15:8];
			3'd2: b = a[23:16];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	always_comb begin
		sfcs_pkg::res_t r [2];
		logic [1:0] n;
		logic [15:0] lm1;
		logic [2:0]  fim1;
		r[0] = '0;
		r[1] = '0;
		n = 2'd0;
		phase_d = phase_q;
		op_d = op_q;
		cur_d = cur_q;
		left_d = left_q;
		pleft_d = pleft_q;
		sav_addr_d = sav_addr_q;
		sav_len_d = sav_len_q;
		fi_d = fi_q;
		lm1 = left_q - 16'd1;
		fim1 = fi_q - 3'd1;
		if (phase_q == PH_IDLE) begin
			if (kind == K_READ || (kind == K_PROG && length != 16'd0)) begin
				op_d = (kind == K_READ) ? OP_READ : OP_PROGRAM;
				cur_d = address;
				left_d = length;
				sav_addr_d = address;
				sav_len_d = length;
				fi_d = FI_START;
				r[0] = sfcs_pkg::mk_spi(8'h03, 1'b0);
				n = 2'd1;
				phase_d = PH_ADDR_RD;
			end else if (kind == K_PROG) begin
				r[0] = sfcs_pkg::mk_done(1'b1);
				n = 2'd1;
			end else if (kind == K_ERASE) begin
				op_d = OP_ERASE;
				cur_d = address;
				r[0] = sfcs_pkg::mk_spi(8'h06, 1'b1);
				n = 2'd1;
				phase_d = PH_WREN;
			end else if (kind == K_ID) begin
				op_d = OP_ID;
				fi_d = 3'd0;
				r[0] = sfcs_pkg::mk_spi(8'h9F, 1'b0);
				n = 2'd1;
				phase_d = PH_ID;
			end
		end else if (phase_q == PH_WAIT_WDATA) begin
			if (kind == K_WDATA) begin
				pleft_d = pleft_q - 13'd1;
				left_d = lm1;
				cur_d = cur_q + 24'd1;
				r[0] = sfcs_pkg::mk_spi(data_byte, pleft_d == 13'd0);
				n = 2'd1;
				phase_d = PH_WDATA;
			end
		end else if (kind == K_RESP) begin
			unique case (phase_q)
				PH_ADDR_RD: begin
					if (fi_q != 3'd0) begin
						fi_d = fim1;
						r[0] = sfcs_pkg::mk_spi(addr_byte(cur_q, fim1),
							fim1 == 3'd0 && left_q == 16'd0);
						n = 2'd1;
					end else if (left_q == 16'd0) begin
						r[0] = sfcs_pkg::mk_done(1'b1);
						n = 2'd1;
						phase_d = PH_IDLE;
					end else begin
						r[0] = sfcs_pkg::mk_spi(8'hFF, left_q == 16'd1);
						n = 2'd1;
						phase_d = PH_RDATA;
					end
				end
				PH_ADDR_WR: begin
					if (fi_q != 3'd0) begin
						fi_d = fim1;
						r[0] = sfcs_pkg::mk_spi(addr_byte(cur_q, fim1),
							fim1 == 3'd0 && op_q == OP_ERASE);
						n = 2'd1;
					end else if (op_q == OP_ERASE) begin
						r[0] = sfcs_pkg::mk_spi(8'h05, 1'b0);
						n = 2'd1;
						phase_d = PH_POLL_CMD;
					end else begin
						r[0] = sfcs_pkg::mk_need();
						n = 2'd1;
						phase_d = PH_WAIT_WDATA;
					end
				end
				PH_RDATA: begin
					left_d = lm1;
					if (op_q == OP_READ) begin
						r[0] = sfcs_pkg::mk_host(data_byte);
						n = 2'd2;
						if (lm1 != 16'd0) begin
							r[1] = sfcs_pkg::mk_spi(8'hFF, lm1 == 16'd1);
						end else begin
							r[1] = sfcs_pkg::mk_done(1'b1);
							phase_d = PH_IDLE;
						end
					end else if (data_byte != 8'hFF) begin
						n = 2'd1;
						if (lm1 != 16'd0) begin
							r[0] = sfcs_pkg::mk_spi(8'hFF, 1'b1);
							phase_d = PH_DRAIN;
						end else begin
							r[0] = sfcs_pkg::mk_done(1'b0);
							phase_d = PH_IDLE;
						end
					end else if (lm1 != 16'd0) begin
						r[0] = sfcs_pkg::mk_spi(8'hFF, lm1 == 16'd1);
						n = 2'd1;
					end else begin
						cur_d = sav_addr_q;
						left_d = sav_len_q;
						pleft_d = page_room(sav_addr_q, sav_len_q, page_lg);
						r[0] = sfcs_pkg::mk_spi(8'h06, 1'b1);
						n = 2'd1;
						phase_d = PH_WREN;
					end
				end
				PH_DRAIN: begin
					r[0] = sfcs_pkg::mk_done(1'b0);
					n = 2'd1;
					phase_d = PH_IDLE;
				end
				PH_WREN: begin
					r[0] = sfcs_pkg::mk_spi((op_q == OP_ERASE) ? 8'h20 : 8'h02, 1'b0);
					n = 2'd1;
					fi_d = FI_START;
					phase_d = PH_ADDR_WR;
				end
				PH_WDATA: begin
					n = 2'd1;
					if (pleft_q != 13'd0) begin
						r[0] = sfcs_pkg::mk_need();
						phase_d = PH_WAIT_WDATA;
					end else begin
						r[0] = sfcs_pkg::mk_spi(8'h05, 1'b0);
						phase_d = PH_POLL_CMD;
					end
				end
				PH_POLL_CMD: begin
					r[0] = sfcs_pkg::mk_spi(8'hFF, 1'b1);
					n = 2'd1;
					phase_d = PH_POLL_STAT;
				end
				PH_POLL_STAT: begin
					n = 2'd1;
					if (data_byte[0]) begin
						r[0] = sfcs_pkg::mk_spi(8'h05, 1'b0);
						phase_d = PH_POLL_CMD;
					end else if (op_q == OP_PROGRAM && left_q != 16'd0) begin
						pleft_d = page_room(cur_q, left_q, page_lg);
						r[0] = sfcs_pkg::mk_spi(8'h06, 1'b1);
						phase_d = PH_WREN;
					end else begin
						r[0] = sfcs_pkg::mk_done(1'b1);
						phase_d = PH_IDLE;
					end
				end
				PH_ID: begin
					if (fi_q != 3'd0) begin
						r[0] = sfcs_pkg::mk_host(data_byte);
						n = 2'd1;
					end
					if (fi_q < 3'd3) begin
						r[n[0]] = sfcs_pkg::mk_spi(8'hFF, fi_q == 3'd2);
						fi_d = fi_q + 3'd1;
					end else begin
						r[n[0]] = sfcs_pkg::mk_done(1'b1);
						phase_d = PH_IDLE;
					end
					n = n + 2'd1;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
		if (n == 2'd1) r[0].last = 1'b1;
		if (n == 2'd2) r[1].last = 1'b1;
		grp.r[0] = r[0];
		grp.r[1] = r[1];
		grp.n = take ? n : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			op_q <= OP_READ;
			cur_q <= '0;
			left_q <= '0;
			pleft_q <= '0;
			sav_addr_q <= '0;
			sav_len_q <= '0;
			fi_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			op_q <= op_d;
			cur_q <= cur_d;
			left_q <= left_d;
			pleft_q <= pleft_d;
			sav_addr_q <= sav_addr_d;
			sav_len_q <= sav_len_d;
			fi_q <= fi_d;
		end
	end
endmodule

>>> sv/sfcs_rq.sv
// Result queue: two groups of up to two results each, drained one result at a time.
// Depends on sfcs_pkg.
`timescale 1ns / 1ps
module sfcs_rq (
	input  logic               clk,
	input  logic               arst_n,
	input  sfcs_pkg::res_grp_t grp,
	output logic               room,
	output logic               vld,
	input  logic               pop,
	output sfcs_pkg::res_t     head,
	output logic [1:0]         count
);
	sfcs_pkg::res_grp_t mem [2];
	logic       wp_q, rp_q, sub_q;
	logic [1:0] cnt_q;
	logic       push, adv;

	assign push = grp.n != 2'd0;
	assign vld = cnt_q != 2'd0;
	assign room = cnt_q != 2'd2;
	assign head = sub_q ? mem[rp_q].r[1] : mem[rp_q].r[0];
	assign adv = pop && vld && (sub_q || mem[rp_q].n != 2'd2);
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			sub_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop && vld) begin
				if (adv) begin
					rp_q <= ~rp_q;
					sub_q <= 1'b0;
				end else begin
					sub_q <= 1'b1;
				end
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, adv};
		end
	end
endmodule
